[hdl/packet_pacing_jitter_monitor_macros.svh]
// Assertion macros shared by the packet pacing and jitter monitor RTL.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef PACKET_PACING_JITTER_MONITOR_MACROS_SVH
`define PACKET_PACING_JITTER_MONITOR_MACROS_SVH

// Same-cycle implication
`define PPJM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PPJM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ppjm_pkg.sv]
// Shared types and constants for the packet pacing and jitter monitor.
// Used by the divider, datapath, controller and top level; no dependencies.
package ppjm_pkg;

    // Field widths
    localparam int TS_W    = 40;   // timestamp
    localparam int CNT_W   = 32;   // packet count
    localparam int PS_W    = 16;   // packet size
    localparam int CFG_W   = 32;   // config write data
    localparam int RATE_W  = 40;   // rate and pause
    localparam int JIT_W   = 48;   // jitter mean
    localparam int BYTES_W = PS_W + CNT_W;
    localparam int USEC_W  = 20;
    localparam int BIG_W   = BYTES_W + USEC_W;  // bytes times microseconds per second
    localparam int IN_W    = 40;
    localparam int OUT_W   = 168;

    // Divider operand widths
    localparam int DIV_HI_W = 40;
    localparam int DIV_LO_W = 48;
    localparam int STEP_W   = 5;

    // Radix-4 iterations per division
    localparam logic [STEP_W-1:0] MEAN_STEPS  = 5'd24;  // 48 quotient bits
    localparam logic [STEP_W-1:0] JIT_STEPS   = 5'd24;  // 48 quotient bits
    localparam logic [STEP_W-1:0] RATE_STEPS  = 5'd20;  // 40 quotient bits
    localparam logic [STEP_W-1:0] PAUSE_STEPS = 5'd21;  // 42 quotient bits

    localparam logic [USEC_W-1:0] US_PER_SEC = 20'd1000000;

    // Saturation limits
    localparam logic [CNT_W-1:0]  MAX_CNT  = {CNT_W{1'b1}};
    localparam logic [RATE_W-1:0] MAX_RATE = {RATE_W{1'b1}};
    localparam logic [JIT_W-1:0]  MAX_JIT  = {JIT_W{1'b1}};

    // Register indexes
    localparam logic [1:0] CFG_PACKET_SIZE  = 2'd0;
    localparam logic [1:0] CFG_TARGET_RATE  = 2'd1;
    localparam logic [1:0] CFG_PACKET_LIMIT = 2'd2;

    // Register reset values
    localparam logic [PS_W-1:0]  PS_RESET = 16'd1024;
    localparam logic [CFG_W-1:0] TR_RESET = 32'd125000000;
    localparam logic [CFG_W-1:0] PL_RESET = 32'd0;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture timestamp, count and gap
        logic calc1;     // byte count, low jitter partial product, scaled gap
        logic calc2;     // byte-microseconds, high jitter partial product
        logic start1;    // start mean-gap and rate divisions
        logic dev;       // deviation, jitter numerator, latch rate
        logic start2;    // start jitter and pause divisions
        logic commit;    // update state, load result register
    } ppjm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_busy;
    } ppjm_sts_t;

endpackage

[hdl/ppjm_div.sv]
// Iterative restoring divider, two quotient bits per cycle.
// Depends on ppjm_pkg; instantiated twice by ppjm_dp.
`include "packet_pacing_jitter_monitor_macros.svh"

module ppjm_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ppjm_pkg::DIV_HI_W-1:0]  num_hi,    // dividend bits above the quotient
    input  logic [ppjm_pkg::DIV_LO_W-1:0]  num_lo,    // remaining bits, left aligned
    input  logic [ppjm_pkg::DIV_HI_W-1:0]  divisor,
    input  logic [ppjm_pkg::STEP_W-1:0]    steps,
    output logic                           busy,
    output logic                           ovf,
    output logic [ppjm_pkg::DIV_LO_W-1:0]  quo
);
    import ppjm_pkg::*;

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [DIV_HI_W-1:0] rem_reg, rem_next;
    logic [DIV_HI_W-1:0] d_reg, d_next;
    logic [DIV_LO_W-1:0] lo_reg, lo_next;
    logic [DIV_LO_W-1:0] q_reg, q_next;

    logic [DIV_HI_W:0]   r1, s1, r2, s2;
    logic                ge1, ge2;

    // Two compare-subtract steps
    always_comb begin
        r1  = {rem_reg, lo_reg[DIV_LO_W-1]};
        ge1 = r1 >= {1'b0, d_reg};
        s1  = ge1 ? r1 - {1'b0, d_reg} : r1;
        r2  = {s1[DIV_HI_W-1:0], lo_reg[DIV_LO_W-2]};
        ge2 = r2 >= {1'b0, d_reg};
        s2  = ge2 ? r2 - {1'b0, d_reg} : r2;
    end

    // Load on start, iterate while busy
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = steps;
            ovf_next  = (divisor == '0) || (num_hi >= divisor);
            rem_next  = num_hi;
            d_next    = divisor;
            lo_next   = num_lo;
            q_next    = '0;
        end else if (busy_reg) begin
            rem_next = s2[DIV_HI_W-1:0];
            lo_next  = {lo_reg[DIV_LO_W-3:0], 2'b00};
            q_next   = {q_reg[DIV_LO_W-3:0], ge1, ge2};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign ovf  = ovf_reg;
    assign quo  = q_reg;

    // Partial remainder stays below the divisor on a valid division
    `PPJM_ASSERT_IMP(a_rem_bound, busy_reg && !ovf_reg, rem_reg < d_reg, "remainder out of range")

endmodule

[hdl/ppjm_dp.sv]
// Datapath: config registers, monitor state, work registers, two dividers.
// Depends on ppjm_pkg and ppjm_div; driven by ppjm_ctrl commands.
`include "packet_pacing_jitter_monitor_macros.svh"

module ppjm_dp #(
    parameter int unsigned JITTER_FRAC_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [ppjm_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic [ppjm_pkg::IN_W-1:0]   in_data,
    input  ppjm_pkg::ppjm_cmd_t         cmd,
    output ppjm_pkg::ppjm_sts_t         sts,
    output logic [ppjm_pkg::OUT_W-1:0]  out_data
);
    import ppjm_pkg::*;

    // Configuration
    logic [PS_W-1:0]  ps_reg;
    logic [CFG_W-1:0] tr_reg;
    logic [CFG_W-1:0] lim_reg;

    // Monitor state
    logic [CNT_W-1:0] sent_reg, sent_next;
    logic [TS_W-1:0]  prev_reg, prev_next;
    logic [JIT_W-1:0] jm_reg, jm_next;
    logic             fin_reg, fin_next;

    // Work registers
    logic [TS_W-1:0]    t_reg, t_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TS_W-1:0]    gap_reg, gap_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [BIG_W-1:0]   big_reg, big_next;
    logic [55:0]        plo_reg, plo_next;
    logic [55:0]        phi_reg, phi_next;
    logic [79:0]        prod_reg, prod_next;
    logic [JIT_W-1:0]   gapq_reg, gapq_next;
    logic [80:0]        num_reg, num_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;

    // Result register
    logic [CNT_W-1:0]  ocnt_reg;
    logic [RATE_W-1:0] orate_reg;
    logic [JIT_W-1:0]  ojit_reg;
    logic [RATE_W-1:0] opause_reg;
    logic              olim_reg;

    logic [TS_W-1:0]  t_in;
    logic [CNT_W-1:0] cm1;
    logic [63:0]      mean_sh, gap_sh;
    logic [JIT_W-1:0] mean_q, dev, jit_new;
    logic [41:0]      pq, tz, pdiff;
    logic [RATE_W-1:0] pause_new;
    logic             lim_hit;

    // Divider ports
    logic                div_start;
    logic [DIV_HI_W-1:0] a_hi, b_hi, a_d, b_d;
    logic [DIV_LO_W-1:0] a_lo, b_lo, a_q, b_q;
    logic [STEP_W-1:0]   a_steps, b_steps;
    logic                a_busy, b_busy, a_ovf, b_ovf;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_reg  <= PS_RESET;
            tr_reg  <= TR_RESET;
            lim_reg <= PL_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PACKET_SIZE:  ps_reg  <= cfg_wdata[PS_W-1:0];
                CFG_TARGET_RATE:  tr_reg  <= cfg_wdata;
                CFG_PACKET_LIMIT: lim_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture: once finished, replay the last figures
    assign t_in     = in_data[TS_W-1:0];
    assign t_next   = fin_reg ? prev_reg : t_in;
    assign cnt_next = (fin_reg || sent_reg == MAX_CNT) ? sent_reg : sent_reg + 1'b1;
    assign gap_next = (t_in >= prev_reg) ? t_in - prev_reg : '0;

    // Products and scaled gap
    assign cm1        = cnt_reg - 1'b1;
    assign bytes_next = cnt_reg * ps_reg;
    assign big_next   = bytes_reg * US_PER_SEC;
    assign plo_next   = jm_reg[23:0] * cm1;
    assign phi_next   = jm_reg[47:24] * cm1;
    assign gap_sh     = 64'(gap_reg) << JITTER_FRAC_BITS;
    assign gapq_next  = (|gap_sh[63:48]) ? MAX_JIT : gap_sh[47:0];
    assign prod_next  = 80'(plo_reg) + (80'(phi_reg) << 24);

    // Deviation from mean gap, jitter numerator
    assign mean_sh   = 64'(t_reg) << JITTER_FRAC_BITS;
    assign mean_q    = a_ovf ? MAX_JIT : a_q;
    assign dev       = (gapq_reg >= mean_q) ? gapq_reg - mean_q : mean_q - gapq_reg;
    assign num_next  = 81'(prod_reg) + 81'(dev);
    assign rate_next = b_ovf ? MAX_RATE : b_q[RATE_W-1:0];

    // Final jitter and pause
    assign jit_new = a_ovf ? MAX_JIT : a_q;
    assign pq      = b_q[41:0];
    assign tz      = 42'(t_reg);
    assign pdiff   = pq - tz;
    always_comb begin
        if (tr_reg == '0) begin
            pause_new = '0;
        end else if (b_ovf) begin
            pause_new = MAX_RATE;
        end else if (pq > tz) begin
            pause_new = (|pdiff[41:40]) ? MAX_RATE : pdiff[RATE_W-1:0];
        end else begin
            pause_new = '0;
        end
    end
    assign lim_hit = (lim_reg != '0) && (cnt_reg == lim_reg);

    // State update on commit, frozen once finished
    always_comb begin
        sent_next = sent_reg;
        prev_next = prev_reg;
        jm_next   = jm_reg;
        fin_next  = fin_reg;
        if (cmd.commit && !fin_reg) begin
            sent_next = cnt_reg;
            prev_next = t_reg;
            jm_next   = jit_new;
            fin_next  = lim_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_reg <= '0;
            prev_reg <= '0;
            jm_reg   <= '0;
            fin_reg  <= 1'b0;
        end else begin
            sent_reg <= sent_next;
            prev_reg <= prev_next;
            jm_reg   <= jm_next;
            fin_reg  <= fin_next;
        end
    end

    // Work registers advance on their commands
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            t_reg   <= t_next;
            cnt_reg <= cnt_next;
            gap_reg <= gap_next;
        end
        if (cmd.calc1) begin
            bytes_reg <= bytes_next;
            plo_reg   <= plo_next;
            gapq_reg  <= gapq_next;
        end
        if (cmd.calc2) begin
            big_reg <= big_next;
            phi_reg <= phi_next;
        end
        if (cmd.start1) begin
            prod_reg <= prod_next;
        end
        if (cmd.dev) begin
            num_reg  <= num_next;
            rate_reg <= rate_next;
        end
        if (cmd.commit) begin
            ocnt_reg   <= cnt_reg;
            orate_reg  <= rate_reg;
            ojit_reg   <= fin_reg ? jm_reg : jit_new;
            opause_reg <= pause_new;
            olim_reg   <= fin_reg | lim_hit;
        end
    end

    // Divider A: mean gap, then jitter; divider B: rate, then pause
    assign div_start = cmd.start1 | cmd.start2;
    always_comb begin
        if (cmd.start2) begin
            a_hi    = DIV_HI_W'(num_reg[80:48]);
            a_lo    = num_reg[47:0];
            a_steps = JIT_STEPS;
            b_hi    = DIV_HI_W'(big_reg[BIG_W-1:42]);
            b_lo    = {big_reg[41:0], 6'b0};
            b_d     = DIV_HI_W'(tr_reg);
            b_steps = PAUSE_STEPS;
        end else begin
            a_hi    = DIV_HI_W'(mean_sh[63:48]);
            a_lo    = mean_sh[47:0];
            a_steps = MEAN_STEPS;
            b_hi    = DIV_HI_W'(big_reg[BIG_W-1:40]);
            b_lo    = {big_reg[39:0], 8'b0};
            b_d     = t_reg;
            b_steps = RATE_STEPS;
        end
        a_d = DIV_HI_W'(cnt_reg);
    end

    ppjm_div u_div_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_hi  (a_hi),
        .num_lo  (a_lo),
        .divisor (a_d),
        .steps   (a_steps),
        .busy    (a_busy),
        .ovf     (a_ovf),
        .quo     (a_q)
    );

    ppjm_div u_div_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_hi  (b_hi),
        .num_lo  (b_lo),
        .divisor (b_d),
        .steps   (b_steps),
        .busy    (b_busy),
        .ovf     (b_ovf),
        .quo     (b_q)
    );

    assign sts.div_busy = a_busy | b_busy;
    assign out_data = {7'b0, olim_reg, opause_reg, ojit_reg, orate_reg, ocnt_reg};

    // Once the limit is met the monitor stays finished
    `PPJM_ASSERT_NXT(a_fin_sticky, fin_reg, fin_reg, "finished flag dropped")

endmodule

[hdl/ppjm_ctrl.sv]
// Controller: sequences one transaction through the datapath and owns the
// input ready and output valid handshake. Depends on ppjm_pkg.
module ppjm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  ppjm_pkg::ppjm_sts_t  sts,
    output ppjm_pkg::ppjm_cmd_t  cmd
);
    import ppjm_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CALC1  = 4'd1;
    localparam logic [3:0] ST_CALC2  = 4'd2;
    localparam logic [3:0] ST_START1 = 4'd3;
    localparam logic [3:0] ST_WAIT1  = 4'd4;
    localparam logic [3:0] ST_DEV    = 4'd5;
    localparam logic [3:0] ST_START2 = 4'd6;
    localparam logic [3:0] ST_WAIT2  = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       mval_reg, mval_next;
    logic       out_free;

    assign out_free = !mval_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CALC1;
                end
            end
            ST_CALC1: begin
                cmd.calc1  = 1'b1;
                state_next = ST_CALC2;
            end
            ST_CALC2: begin
                cmd.calc2  = 1'b1;
                state_next = ST_START1;
            end
            ST_START1: begin
                cmd.start1 = 1'b1;
                state_next = ST_WAIT1;
            end
            ST_WAIT1: begin
                if (!sts.div_busy) begin
                    state_next = ST_DEV;
                end
            end
            ST_DEV: begin
                cmd.dev    = 1'b1;
                state_next = ST_START2;
            end
            ST_START2: begin
                cmd.start2 = 1'b1;
                state_next = ST_WAIT2;
            end
            ST_WAIT2: begin
                if (!sts.div_busy) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the result register is free
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output valid: set on commit, drop when taken
    assign mval_next = cmd.commit | (mval_reg & !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mval_reg;

endmodule

[hdl/packet_pacing_jitter_monitor.sv]
// Channel   Ports            Payload (lowest bit first)
// input     s_axis_*         timestamp_us[39:0]
// result    m_axis_*         packet_count, rate_bytes_per_sec, jitter_us_q8,
//                            pause_us, limit_reached, zero fill
// config    cfg_*            index 0 packet_size, 1 target_rate, 2 packet_limit
//
// Between acceptance and result valid, each transaction runs two radix-4
// dividers twice each (24 iterations max per division).
// Reset is synchronous on aresetn low and restores the register defaults.
// The result waits in an output register; the next input transaction is taken
// meanwhile, and the block holds before its commit only if that result is still
// not taken. Depends on ppjm_pkg, ppjm_ctrl, ppjm_dp.
`include "packet_pacing_jitter_monitor_macros.svh"

module packet_pacing_jitter_monitor #(
    parameter int unsigned JITTER_FRAC_BITS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [ppjm_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ppjm_pkg::IN_W-1:0]   s_axis_tdata,   // timestamp_us[39:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // packet_count[31:0], rate_bytes_per_sec[71:32], jitter_us_q8[119:72],
    // pause_us[159:120], limit_reached[160], zero[167:161]
    output logic [ppjm_pkg::OUT_W-1:0]  m_axis_tdata
);
    import ppjm_pkg::*;

    ppjm_cmd_t cmd;
    ppjm_sts_t sts;

    ppjm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ppjm_dp #(
        .JITTER_FRAC_BITS (JITTER_FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_axis_tdata)
    );

    // Divisions are running the cycle after a start
    `PPJM_ASSERT_NXT(a_start_busy, cmd.start1 || cmd.start2, sts.div_busy, "divider not started")
    // Commit only once both divisions are done
    `PPJM_ASSERT_IMP(a_commit_idle, cmd.commit, !sts.div_busy, "commit while dividing")
    // An accepted transaction blocks further input
    `PPJM_ASSERT_NXT(a_accept_block, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                     "input taken while busy")

endmodule

[verif/tb_packet_pacing_jitter_monitor.sv]
// Self-checking testbench for packet_pacing_jitter_monitor: drives timestamp streams through
// several register settings and checks every result against a built-in predictor.
// Depends on ppjm_pkg and the packet_pacing_jitter_monitor RTL only.
`timescale 1ns / 100ps

import ppjm_pkg::*;

// Expected figures of one result transaction
typedef struct {
    logic [CNT_W-1:0]  count;
    logic [RATE_W-1:0] rate;
    logic [JIT_W-1:0]  jitter;
    logic [RATE_W-1:0] pause;
    logic              limit;
} pacing_result_t;

// Pacing predictor plus the queue of figures still owed by the block
class pacing_scoreboard #(int unsigned FRAC_BITS = 8);
    logic [PS_W-1:0]   pkt_size;
    logic [CFG_W-1:0]  tgt_rate;
    logic [CFG_W-1:0]  pkt_limit;
    logic [CNT_W-1:0]  count;
    logic [TS_W-1:0]   prev_t;
    logic [JIT_W-1:0]  jit;
    logic              done;
    int                errors;
    pacing_result_t    pending[$];

    function new();
        pkt_size  = PS_RESET;
        tgt_rate  = TR_RESET;
        pkt_limit = PL_RESET;
        count     = '0;
        prev_t    = '0;
        jit       = '0;
        done      = 1'b0;
        errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            CFG_PACKET_SIZE:  pkt_size  = val[PS_W-1:0];
            CFG_TARGET_RATE:  tgt_rate  = val;
            CFG_PACKET_LIMIT: pkt_limit = val;
            default: ;
        endcase
    endfunction

    // floor(a*b/d) on a full-width product, capped; a zero divisor gives the cap
    function logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b, logic [63:0] d,
                                          logic [63:0] cap);
        logic [127:0] q;
        if (d == 0)
            return cap;
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
        return (q > {64'd0, cap}) ? cap : q[63:0];
    endfunction

    function pacing_result_t current_figures();
        pacing_result_t r;
        logic [63:0] bytes;
        logic [63:0] ideal;
        bytes    = 64'(count) * 64'(pkt_size);
        r.count  = count;
        r.rate   = RATE_W'(scaled_quotient(bytes, 64'(US_PER_SEC), 64'(prev_t),
                                           64'(MAX_RATE)));
        r.jitter = jit;
        r.pause  = '0;
        // Pause only when pacing is on and the sender is ahead of schedule
        if (tgt_rate != 0) begin
            ideal = scaled_quotient(bytes, 64'(US_PER_SEC), 64'(tgt_rate), '1);
            if (ideal > 64'(prev_t))
                r.pause = (ideal - 64'(prev_t) > 64'(MAX_RATE)) ? MAX_RATE
                                                                 : RATE_W'(ideal - 64'(prev_t));
        end
        r.limit = done;
        return r;
    endfunction

    // Advance the pacing state for one accepted timestamp and queue its figures
    function void note_stamp(logic [TS_W-1:0] ts);
        logic [CNT_W-1:0] n;
        logic [TS_W-1:0]  gap;
        logic [63:0]      mean_q;
        logic [63:0]      gap_q;
        logic [63:0]      dev;
        logic [127:0]     num;
        logic [127:0]     q;
        if (!done) begin
            n      = (count != MAX_CNT) ? count + 1'b1 : count;
            // a step backwards counts as no gap at all
            gap    = (ts >= prev_t) ? ts - prev_t : '0;
            mean_q = scaled_quotient(64'(ts), 64'(1) << FRAC_BITS, 64'(n), 64'(MAX_JIT));
            gap_q  = scaled_quotient(64'(gap), 64'(1) << FRAC_BITS, 64'd1, 64'(MAX_JIT));
            dev    = (gap_q >= mean_q) ? gap_q - mean_q : mean_q - gap_q;
            num    = 128'(jit) * 128'(n - 1'b1) + 128'(dev);
            q      = num / 128'(n);
            jit    = (q > 128'(MAX_JIT)) ? MAX_JIT : q[JIT_W-1:0];
            count  = n;
            prev_t = ts;
            if (pkt_limit != 0 && n == pkt_limit)
                done = 1'b1;
        end
        pending.push_back(current_figures());
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        if (errors < 100)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    task check_result(logic [OUT_W-1:0] data);
        pacing_result_t want;
        if (pending.size() == 0) begin
            report("result with no transaction pending", 64'(data[31:0]), 64'd0);
            return;
        end
        want = pending.pop_front();
        if (data[31:0] !== want.count)
            report("packet_count", 64'(data[31:0]), 64'(want.count));
        if (data[71:32] !== want.rate)
            report("rate_bytes_per_sec", 64'(data[71:32]), 64'(want.rate));
        if (data[119:72] !== want.jitter)
            report("jitter_us_q8", 64'(data[119:72]), 64'(want.jitter));
        if (data[159:120] !== want.pause)
            report("pause_us", 64'(data[159:120]), 64'(want.pause));
        if (data[160] !== want.limit)
            report("limit_reached", 64'(data[160]), 64'(want.limit));
        if (data[167:161] !== '0)
            report("zero fill", 64'(data[167:161]), 64'd0);
    endtask
endclass

module tb_packet_pacing_jitter_monitor;

    localparam int unsigned FRAC        = 8;
    localparam int          HOLD_CYCLES = 600;
    localparam int          QUIET_LIMIT = 5000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 230;
    localparam logic [1:0]  CFG_SPARE   = 2'd3;   // unmapped register index
    localparam logic [TS_W-1:0] TS_MAX  = {TS_W{1'b1}};

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [1:0]          cfg_index     = '0;
    logic [CFG_W-1:0]    cfg_wdata     = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;   // timestamp_us[39:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // packet_count[31:0], rate_bytes_per_sec[71:32], jitter_us_q8[119:72],
    // pause_us[159:120], limit_reached[160], zero[167:161]
    logic [OUT_W-1:0]    m_axis_tdata;

    pacing_scoreboard #(FRAC) sb;
    bit                  burst_mode = 1'b0;
    bit                  hold_req   = 1'b0;
    logic [TS_W-1:0]     send_clock_us = '0;
    int                  quiet_cycles = 0;

    packet_pacing_jitter_monitor #(
        .JITTER_FRAC_BITS(FRAC)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 aclk = ~aclk;

    // Hold reset low at the start, once, then release it
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // End the run if no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic int unsigned draw_wait();
        return burst_mode ? 0 : $urandom_range(0, 11);
    endfunction

    // Result side: stall at random, hold off for a long stretch on request, check each result
    initial begin
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = draw_wait();
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            sb.check_result(m_axis_tdata);
        end
    end

    // Offer one timestamp after a random gap; keep tvalid high when no gap follows
    task automatic send_stamp(logic [TS_W-1:0] ts);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ts;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_stamp(ts);
    endtask

    // Stop offering and wait until every queued result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Mostly forward steps of the running send clock, with some backward steps,
    // repeats, wild values and the top of the range mixed in
    function automatic logic [TS_W-1:0] next_stamp(int unsigned span);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            send_clock_us = send_clock_us + $urandom_range(0, span);
        else if (pick < 88)
            send_clock_us = send_clock_us - $urandom_range(1, span);
        else if (pick < 93)
            send_clock_us = send_clock_us;
        else if (pick < 97)
            send_clock_us = TS_W'({$urandom, $urandom});
        else
            send_clock_us = TS_MAX;
        return send_clock_us;
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 5))
            0: return 32'd1;
            1: return 32'd65535;
            2: return 32'd1024;
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2: return 32'd125000000;
            3: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // Limits that cannot be met within the run: off, maximum, already passed, far ahead
    function automatic logic [CFG_W-1:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, int'(sb.count));
            default: return sb.count + 32'd100000;
        endcase
    endfunction

    initial begin
        int unsigned span;
        sb = new();
        wait (aresetn === 1'b1);
        @(posedge aclk);

        // Defaults: zero time, repeats, backward steps, top of the timestamp range
        send_stamp(40'd0);
        send_stamp(40'd0);
        send_stamp(40'd1000);
        send_stamp(40'd500);
        send_stamp(TS_MAX);
        send_stamp(40'd100);
        send_stamp(TS_MAX);
        send_stamp(40'h55_5555_5555);
        wait_drained();

        // Zero packet size gives zero bytes
        write_reg(CFG_PACKET_SIZE, 32'd0);
        send_stamp(40'd5000);
        send_stamp(40'd6000);
        wait_drained();

        // Largest size (upper write bits dropped) with the slowest rate drives a long pause
        write_reg(CFG_PACKET_SIZE, 32'hFFFF_FFFF);
        write_reg(CFG_TARGET_RATE, 32'd1);
        send_stamp(40'd7000);
        send_stamp(40'd7001);
        wait_drained();

        // Zero rate turns pacing off; then the fastest rate
        write_reg(CFG_TARGET_RATE, 32'd0);
        send_stamp(40'd8000);
        wait_drained();
        write_reg(CFG_TARGET_RATE, 32'hFFFF_FFFF);
        write_reg(CFG_PACKET_SIZE, 32'd1);
        send_stamp(40'd9000);
        send_stamp(40'd10000);
        wait_drained();

        // Unmapped index, a limit already passed, the largest limit
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        write_reg(CFG_PACKET_LIMIT, 32'd2);
        send_stamp(40'd11000);
        wait_drained();
        write_reg(CFG_PACKET_LIMIT, 32'hFFFF_FFFF);
        send_stamp(40'd12000);
        send_stamp(40'd1);
        wait_drained();
        send_clock_us = 40'd1;

        // Random phases, each under its own register setting and idling pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_reg(CFG_PACKET_SIZE, pick_size());
            write_reg(CFG_TARGET_RATE, pick_rate());
            write_reg(CFG_PACKET_LIMIT, pick_limit());
            burst_mode = (ph % 4 == 1);
            case (ph % 4)
                0: span = 4;
                1: span = 1000;
                2: span = 100000;
                default: span = 32'h4000_0000;
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // stall the result side long enough to back up the input
                if (ph == 2 && i == 40)
                    hold_req = 1'b1;
                send_stamp(next_stamp(span));
            end
        end

        // Reach the packet limit, then keep sending past done
        wait_drained();
        burst_mode = 1'b0;
        write_reg(CFG_PACKET_SIZE, 32'd1500);
        write_reg(CFG_TARGET_RATE, 32'd125000000);
        write_reg(CFG_PACKET_LIMIT, sb.count + 32'd40);
        for (int i = 0; i < 60; i++)
            send_stamp(next_stamp(5000));
        wait_drained();

        // Registers still change the frozen figures after done
        write_reg(CFG_PACKET_SIZE, pick_size());
        write_reg(CFG_TARGET_RATE, pick_rate());
        for (int i = 0; i < 10; i++)
            send_stamp(next_stamp(5000));
        wait_drained();

        // Let any stray result surface
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/ppjm_pkg.sv
hdl/ppjm_div.sv
hdl/ppjm_dp.sv
hdl/ppjm_ctrl.sv
hdl/packet_pacing_jitter_monitor.sv
verif/tb_packet_pacing_jitter_monitor.sv
